@@ hdl/uv16_pkg.sv @@
// ----------------------------------------------------------------------------
// Unit vector codec package
// Shared widths, constants, command codes and the per-item record that
// travels down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package uv16_pkg;

   // Largest supported number of fraction bits; record widths are sized for it.
   localparam int FRAC_MAX = 14;

   // Decoded magnitude width (values up to 2^FRAC).
   localparam int Q_W   = FRAC_MAX + 1;
   // Squared bin value shifted left by 2*(FRAC+1).
   localparam int RHS_W = 14 + 2 * (FRAC_MAX + 1);
   // Running square accumulator, with headroom for a trial step.
   localparam int ACC_W = RHS_W + 6;
   // Encode dividend 126*|c| and divisor |x|+|y|+|z|.
   localparam int NUM_W = 22;
   localparam int DEN_W = 17;
   // Octant bin width and bin norm width.
   localparam int BIN_W = 7;
   localparam int NRM_W = 16;

   // Command codes.
   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   // Octant plane constants.
   localparam logic [BIN_W-1:0] BIN_SPAN = 7'd126;
   localparam logic [BIN_W-1:0] BIN_FOLD = 7'd127;
   localparam logic [BIN_W-1:0] BIN_HALF = 7'd64;

   // Per-item record carried from cell to cell.
   typedef struct packed {
      logic                        cmd;
      logic                        tiny;
      logic                        sx;
      logic                        sy;
      logic                        sz;
      logic [NUM_W-1:0]            rem_x;
      logic [NUM_W-1:0]            rem_y;
      logic [DEN_W-1:0]            den;
      logic [BIN_W-1:0]            qx;
      logic [BIN_W-1:0]            qy;
      logic [NRM_W-1:0]            nrm;
      logic [2:0][RHS_W-1:0]       rhs;
      logic [2:0][ACC_W-1:0]       acc;
      logic [2:0][ACC_W-1:0]       prod;
      logic [2:0][Q_W-1:0]         q;
   } uv16_work_type;

endpackage

`default_nettype wire

@@ hdl/uv16_front.sv @@
// ----------------------------------------------------------------------------
// Unit vector codec front end
// Two register stages: magnitudes, squares and code unpacking, then the
// threshold test and the initial values for the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module uv16_front #(
   parameter int FRAC_BITS = 14
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic                  in_cmd,
   input  wire logic [15:0]           in_x,
   input  wire logic [15:0]           in_y,
   input  wire logic [15:0]           in_z,
   input  wire logic [15:0]           in_code,
   input  wire logic [31:0]           min_length_sq,
   output      logic                  out_valid,
   output      uv16_pkg::uv16_work_type out_work
);

   localparam int MAG_W = 17;
   localparam int SQ_W  = 31;
   localparam int LEN_W = 33;
   localparam int BW    = uv16_pkg::BIN_W;

   // Stage A inputs.
   logic [MAG_W-1:0] ax_in, ay_in, az_in;
   logic [33:0]      sqx_full, sqy_full, sqz_full;
   logic [7:0]       bsum;
   logic             fold;
   logic [BW-1:0]    xb_in, yb_in, mz_in;
   logic [8:0]       zraw;
   logic             zneg;

   // Stage A registers.
   logic             a_valid_ff;
   logic             a_cmd_ff;
   logic [MAG_W-1:0] a_ax_ff, a_ay_ff;
   logic [uv16_pkg::DEN_W-1:0] a_sum_ff;
   logic [SQ_W-1:0]  a_sqx_ff, a_sqy_ff, a_sqz_ff;
   logic             a_sx_ff, a_sy_ff, a_sz_ff;
   logic [2:0][BW-1:0] a_bin_ff;

   // Stage B.
   logic [LEN_W-1:0] len2;
   logic [2:0][uv16_pkg::NRM_W-1:0] csq;
   logic [uv16_pkg::NRM_W-1:0] nrm;
   uv16_pkg::uv16_work_type work_in;
   uv16_pkg::uv16_work_type work_ff;
   logic             valid_ff;

   // Magnitudes of the signed components; the most negative value maps to 2^15.
   assign ax_in = in_x[15] ? (17'h10000 - {1'b0, in_x}) : {1'b0, in_x};
   assign ay_in = in_y[15] ? (17'h10000 - {1'b0, in_y}) : {1'b0, in_y};
   assign az_in = in_z[15] ? (17'h10000 - {1'b0, in_z}) : {1'b0, in_z};

   assign sqx_full = 34'(ax_in) * 34'(ax_in);
   assign sqy_full = 34'(ay_in) * 34'(ay_in);
   assign sqz_full = 34'(az_in) * 34'(az_in);

   // Unpack the code and unfold the upper half of the octant.
   always_comb begin
      bsum  = {2'b0, in_code[12:7]} + {1'b0, in_code[6:0]};
      fold  = (bsum >= {1'b0, uv16_pkg::BIN_FOLD});
      xb_in = fold ? (uv16_pkg::BIN_FOLD - {1'b0, in_code[12:7]}) : {1'b0, in_code[12:7]};
      yb_in = fold ? (uv16_pkg::BIN_FOLD - in_code[6:0]) : in_code[6:0];
      zraw  = {2'b0, uv16_pkg::BIN_SPAN} - {2'b0, xb_in} - {2'b0, yb_in};
      zneg  = zraw[8];
      mz_in = zneg ? 7'(-zraw) : zraw[6:0];
   end

   // Stage A register.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_cmd_ff <= in_cmd;
         a_ax_ff  <= ax_in;
         a_ay_ff  <= ay_in;
         a_sum_ff <= uv16_pkg::DEN_W'(ax_in + ay_in + az_in);
         a_sqx_ff <= sqx_full[SQ_W-1:0];
         a_sqy_ff <= sqy_full[SQ_W-1:0];
         a_sqz_ff <= sqz_full[SQ_W-1:0];
         a_bin_ff <= {mz_in, yb_in, xb_in};
         if (in_cmd == uv16_pkg::CMD_DECODE) begin
            a_sx_ff <= in_code[15];
            a_sy_ff <= in_code[14];
            a_sz_ff <= in_code[13] ^ zneg;
         end else begin
            a_sx_ff <= in_x[15];
            a_sy_ff <= in_y[15];
            a_sz_ff <= in_z[15];
         end
      end
   end

   // Threshold test and starting values of the cell chain.
   always_comb begin
      len2 = LEN_W'(a_sqx_ff) + LEN_W'(a_sqy_ff) + LEN_W'(a_sqz_ff);
      for (int i = 0; i < 3; i++) begin
         csq[i] = uv16_pkg::NRM_W'(a_bin_ff[i]) * uv16_pkg::NRM_W'(a_bin_ff[i]);
      end
      nrm = csq[0] + csq[1] + csq[2];

      work_in       = '0;
      work_in.cmd   = a_cmd_ff;
      work_in.tiny  = (a_cmd_ff == uv16_pkg::CMD_ENCODE) &&
                      ((len2 < LEN_W'(min_length_sq)) || (a_sum_ff == '0));
      work_in.sx    = a_sx_ff;
      work_in.sy    = a_sy_ff;
      work_in.sz    = a_sz_ff;
      work_in.rem_x = uv16_pkg::NUM_W'(a_ax_ff) * uv16_pkg::NUM_W'(uv16_pkg::BIN_SPAN);
      work_in.rem_y = uv16_pkg::NUM_W'(a_ay_ff) * uv16_pkg::NUM_W'(uv16_pkg::BIN_SPAN);
      work_in.den   = a_sum_ff;
      work_in.nrm   = nrm;
      for (int i = 0; i < 3; i++) begin
         work_in.rhs[i]  = uv16_pkg::RHS_W'(csq[i]) << (2 * (FRAC_BITS + 1));
         work_in.acc[i]  = uv16_pkg::ACC_W'(nrm);
         work_in.prod[i] = -uv16_pkg::ACC_W'(nrm);
      end
   end

   // Stage B register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

`default_nettype wire

@@ hdl/uv16_cell.sv @@
// ----------------------------------------------------------------------------
// Unit vector codec cell
// Settles one result bit: one trial bit of each decoded magnitude and, in the
// low cells, one quotient bit of each encode division.
// ----------------------------------------------------------------------------
`default_nettype none

module uv16_cell #(
   parameter int FRAC_BITS = 14,
   parameter int BIT       = 0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_valid,
   input  wire uv16_pkg::uv16_work_type in_work,
   output      logic                    out_valid,
   output      uv16_pkg::uv16_work_type out_work
);

   localparam int AW = uv16_pkg::ACC_W;
   localparam int DW = uv16_pkg::NUM_W + 2;

   uv16_pkg::uv16_work_type dec_work;
   uv16_pkg::uv16_work_type div_work;
   uv16_pkg::uv16_work_type work_ff;
   logic                    valid_ff;
   logic [AW-1:0]           cand [3];

   // Trial of bit BIT of q: accept when (2q-1)^2 * n stays within c^2 * 4^(F+1).
   // acc holds (2q-1)^2 * n and prod holds (2q-1) * n, both kept incrementally.
   always_comb begin
      dec_work = in_work;
      for (int i = 0; i < 3; i++) begin
         cand[i] = in_work.acc[i] + (in_work.prod[i] << (BIT + 2)) +
                   (AW'(in_work.nrm) << (2 * BIT + 2));
         if ($signed(cand[i]) <= $signed(AW'(in_work.rhs[i]))) begin
            dec_work.acc[i]    = cand[i];
            dec_work.prod[i]   = in_work.prod[i] + (AW'(in_work.nrm) << (BIT + 1));
            dec_work.q[i][BIT] = 1'b1;
         end
      end
   end

   // Restoring division step for the encode bins.
   if (BIT < uv16_pkg::BIN_W) begin : g_div
      logic [DW-1:0] dsh;
      always_comb begin
         div_work = dec_work;
         dsh      = DW'(dec_work.den) << BIT;
         if (DW'(dec_work.rem_x) >= dsh) begin
            div_work.rem_x   = dec_work.rem_x - dsh[uv16_pkg::NUM_W-1:0];
            div_work.qx[BIT] = 1'b1;
         end
         if (DW'(dec_work.rem_y) >= dsh) begin
            div_work.rem_y   = dec_work.rem_y - dsh[uv16_pkg::NUM_W-1:0];
            div_work.qy[BIT] = 1'b1;
         end
      end
   end else begin : g_nodiv
      assign div_work = dec_work;
   end

   // Hand the record to the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         work_ff <= div_work;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

`default_nettype wire

@@ hdl/uv16_back.sv @@
// ----------------------------------------------------------------------------
// Unit vector codec back end
// Folds and packs the encode bins, applies signs to decoded magnitudes and
// holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module uv16_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_valid,
   input  wire uv16_pkg::uv16_work_type in_work,
   output      logic                    out_valid,
   output      logic [15:0]             code_out,
   output      logic                    was_tiny,
   output      logic [15:0]             out_x,
   output      logic [15:0]             out_y,
   output      logic [15:0]             out_z
);

   logic [uv16_pkg::BIN_W-1:0] xb, yb;
   logic [15:0]                code_in, mx, my, mz;
   logic [15:0]                x_in, y_in, z_in;
   logic                       valid_ff;
   logic [15:0]                code_ff, x_ff, y_ff, z_ff;
   logic                       tiny_ff;

   // Result formatting.
   always_comb begin
      xb = in_work.qx;
      yb = in_work.qy;
      if (in_work.qx >= uv16_pkg::BIN_HALF) begin
         xb = uv16_pkg::BIN_FOLD - in_work.qx;
         yb = uv16_pkg::BIN_FOLD - in_work.qy;
      end
      mx = 16'(in_work.q[0]);
      my = 16'(in_work.q[1]);
      mz = 16'(in_work.q[2]);
      code_in = '0;
      x_in    = '0;
      y_in    = '0;
      z_in    = '0;
      if (in_work.cmd == uv16_pkg::CMD_DECODE) begin
         x_in = in_work.sx ? -mx : mx;
         y_in = in_work.sy ? -my : my;
         z_in = in_work.sz ? -mz : mz;
      end else if (!in_work.tiny) begin
         code_in = {in_work.sx, in_work.sy, in_work.sz, xb[5:0], yb};
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         code_ff <= code_in;
         tiny_ff <= in_work.tiny;
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
      end
   end

   assign out_valid = valid_ff;
   assign code_out  = code_ff;
   assign was_tiny  = tiny_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

`default_nettype wire

@@ hdl/unit_vector_16bit_codec.sv @@
// ----------------------------------------------------------------------------
// Unit vector 16-bit codec
// Packs 3-component unit vectors into 16-bit octant codes and back.
// ----------------------------------------------------------------------------
// The block takes one item per cycle unless the result side stalls. It has
// two front stages, a chain of FRAC_BITS + 1 cells that each settle one
// bit of the decoded magnitudes, the last seven of which also settle one bit of
// the encode division, and the output register. The whole pipeline advances
// whenever the output register is empty or its transfer completes, so a stall
// on the result side holds every stage in place. The length threshold is
// written through csr_wr_en and csr_wr_data and resets to 3.
`default_nettype none

module unit_vector_16bit_codec #(
   parameter int FRAC_BITS = 14
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [63:0] req_tdata,  // comp_x, comp_y, comp_z, code_in
   input  wire logic        req_tuser,  // cmd
   // Response channel.
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,  // code_out, out_x, out_y, out_z
   output      logic        rsp_tuser,  // was_tiny
   // Threshold register.
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   localparam int NCELL = FRAC_BITS + 1;

   logic                    en;
   logic [31:0]             min_len_ff;
   logic                    valid_chain [NCELL+1];
   uv16_pkg::uv16_work_type work_chain  [NCELL+1];
   logic [15:0]             code_out, out_x, out_y, out_z;
   logic                    was_tiny;

   // Pipeline advance.
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= 32'd3;
      end else if (csr_wr_en) begin
         min_len_ff <= csr_wr_data;
      end
   end

   uv16_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (req_tvalid),
      .in_cmd        (req_tuser),
      .in_x          (req_tdata[15:0]),
      .in_y          (req_tdata[31:16]),
      .in_z          (req_tdata[47:32]),
      .in_code       (req_tdata[63:48]),
      .min_length_sq (min_len_ff),
      .out_valid     (valid_chain[0]),
      .out_work      (work_chain[0])
   );

   // Cell chain, most significant bit first.
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      uv16_cell #(.FRAC_BITS(FRAC_BITS), .BIT(FRAC_BITS - i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (valid_chain[i]),
         .in_work   (work_chain[i]),
         .out_valid (valid_chain[i+1]),
         .out_work  (work_chain[i+1])
      );
   end

   uv16_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (valid_chain[NCELL]),
      .in_work   (work_chain[NCELL]),
      .out_valid (rsp_tvalid),
      .code_out  (code_out),
      .was_tiny  (was_tiny),
      .out_x     (out_x),
      .out_y     (out_y),
      .out_z     (out_z)
   );

   assign rsp_tdata = {out_z, out_y, out_x, code_out};
   assign rsp_tuser = was_tiny;

   // A tiny vector always carries a zero code.
   a_tiny_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 64'd0)
      else $error("tiny result with nonzero payload");

   // An encode code never comes with decoded components.
   a_code_only : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15:0] != 16'd0 |-> rsp_tdata[63:16] == 48'd0)
      else $error("encode result with decoded components");

   // The request side stalls only behind a held result.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled without a held result");

endmodule

`default_nettype wire

@@ tb/uv16_checker.sv @@
// ----------------------------------------------------------------------------
// Unit vector codec checker
// Watches both stream channels and the threshold write port, predicts each
// result from the accepted request and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uv16_checker #(
   parameter int FRAC_BITS = 14
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata,
   input  wire logic        rsp_tuser,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   output int               fail_count,
   output int               pending,
   output int               encodes_seen,
   output int               decodes_seen,
   output int               tiny_seen
);

   typedef struct packed {
      logic [15:0] code;
      logic        tiny;
      logic [15:0] vx;
      logic [15:0] vy;
      logic [15:0] vz;
   } codec_result_type;

   codec_result_type result_queue[$];
   logic [31:0]      length_floor;

   // Magnitude of a 16-bit two's complement value.
   function automatic logic [16:0] magnitude(input logic [15:0] v);
      return v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
   endfunction

   // Largest q with q == 0 or (2q-1)^2 * n <= c^2 * 2^(2*(FRAC+1)).
   function automatic logic [15:0] unit_scale(input int unsigned c, input int unsigned n);
      longint unsigned lim, lo, hi, mid, t;
      lim = (longint'(c) * c) << (2 * (FRAC_BITS + 1));
      lo = 0;
      hi = 64'd1 << (FRAC_BITS + 1);
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         t = 2 * mid - 1;
         if (t * t * n <= lim) lo = mid;
         else hi = mid - 1;
      end
      return lo[15:0];
   endfunction

   function automatic logic [15:0] apply_sign(input logic [15:0] m, input logic neg);
      return neg ? -m : m;
   endfunction

   function automatic codec_result_type predict_codec(input logic cmd, input logic [63:0] d);
      codec_result_type r;
      logic [16:0] ax, ay, az;
      longint unsigned len2;
      int unsigned sum, xb, yb;
      int xs, ys, zs, nrm;
      logic [15:0] code;
      r = '0;
      if (cmd == uv16_pkg::CMD_ENCODE) begin
         ax = magnitude(d[15:0]);
         ay = magnitude(d[31:16]);
         az = magnitude(d[47:32]);
         len2 = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
         sum = ax + ay + az;
         if (len2 < length_floor || sum == 0) begin
            r.tiny = 1'b1;
         end else begin
            xb = (126 * ax) / sum;
            yb = (126 * ay) / sum;
            if (xb >= 64) begin
               xb = 127 - xb;
               yb = 127 - yb;
            end
            r.code = {d[15], d[31], d[47], xb[5:0], yb[6:0]};
         end
      end else begin
         code = d[63:48];
         xs = int'(code[12:7]);
         ys = int'(code[6:0]);
         if (xs + ys >= 127) begin
            xs = 127 - xs;
            ys = 127 - ys;
         end
         zs = 126 - xs - ys;
         nrm = xs * xs + ys * ys + zs * zs;
         r.vx = apply_sign(unit_scale(xs, nrm), code[15]);
         r.vy = apply_sign(unit_scale(ys, nrm), code[14]);
         r.vz = apply_sign(unit_scale(zs < 0 ? -zs : zs, nrm), code[13] ^ (zs < 0));
      end
      return r;
   endfunction

   // Track the threshold, queue predictions, and compare results.
   always @(posedge clock) begin
      codec_result_type want;
      int               errs;
      errs = 0;
      if (reset) begin
         length_floor <= 32'd3;
         result_queue.delete();
         fail_count <= 0;
         pending <= 0;
         encodes_seen <= 0;
         decodes_seen <= 0;
         tiny_seen <= 0;
      end else begin
         if (csr_wr_en) length_floor <= csr_wr_data;
         if (req_tvalid && req_tready) begin
            result_queue.push_back(predict_codec(req_tuser, req_tdata));
            if (req_tuser == uv16_pkg::CMD_DECODE) decodes_seen <= decodes_seen + 1;
            else encodes_seen <= encodes_seen + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (result_queue.size() == 0) begin
               $error("result transfer with no prediction waiting");
               errs++;
            end else begin
               want = result_queue.pop_front();
               if (want.tiny) tiny_seen <= tiny_seen + 1;
               if (rsp_tdata[15:0] !== want.code) begin
                  $error("code_out expected %h actual %h", want.code, rsp_tdata[15:0]);
                  errs++;
               end
               if (rsp_tuser !== want.tiny) begin
                  $error("was_tiny expected %b actual %b", want.tiny, rsp_tuser);
                  errs++;
               end
               if (rsp_tdata[31:16] !== want.vx) begin
                  $error("out_x expected %h actual %h", want.vx, rsp_tdata[31:16]);
                  errs++;
               end
               if (rsp_tdata[47:32] !== want.vy) begin
                  $error("out_y expected %h actual %h", want.vy, rsp_tdata[47:32]);
                  errs++;
               end
               if (rsp_tdata[63:48] !== want.vz) begin
                  $error("out_z expected %h actual %h", want.vz, rsp_tdata[63:48]);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending    <= result_queue.size();
      end
   end
endmodule

`default_nettype wire

@@ tb/tb_unit_vector_16bit_codec.sv @@
// ----------------------------------------------------------------------------
// Unit vector codec testbench
// Drives encode and decode requests with random gaps and result stalls over
// several length thresholds; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_unit_vector_16bit_codec;

   localparam int FRAC_BITS = 14;
   localparam int LATENCY   = FRAC_BITS + 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;
   int          fail_count, pending, encodes_seen, decodes_seen, tiny_seen;
   bit          stimulus_done = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   unit_vector_16bit_codec #(.FRAC_BITS(FRAC_BITS)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   uv16_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending(pending),
      .encodes_seen(encodes_seen), .decodes_seen(decodes_seen),
      .tiny_seen(tiny_seen)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Result side: random stalls, with calm stretches where it is always ready.
   initial begin : rsp_stall
      int stall;
      while (1) begin
         @(posedge clock);
         if ($urandom_range(0, 7) == 0) begin
            stall = gap_length();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 20) == 0) repeat ($urandom_range(20, 80)) @(posedge clock);
      end
   end

   // Offer one item and hold it until the transfer; valid drops only for a gap.
   task automatic send_item(input logic cmd, input logic [63:0] data);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop offering items.
   task automatic idle_request();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_encode(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
      send_item(uv16_pkg::CMD_ENCODE, {16'h0000, z, y, x});
   endtask

   task automatic send_decode(input logic [15:0] code);
      send_item(uv16_pkg::CMD_DECODE, {code, 48'h0});
   endtask

   // Threshold writes only with the pipeline empty.
   task automatic write_threshold(input logic [31:0] value);
      idle_request();
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // A random component, biased toward extremes and small values.
   function automatic logic [15:0] rand_comp();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'($signed($urandom_range(0, 8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 1)) send_decode(16'($urandom));
         else send_encode(rand_comp(), rand_comp(), rand_comp());
      end
   endtask

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, zero components, tiny inputs and the fold edges.
      send_encode(16'h4000, 16'h0000, 16'h0000);
      send_encode(16'h8000, 16'h8000, 16'h8000);
      send_encode(16'h7fff, 16'h7fff, 16'h7fff);
      send_encode(16'h0000, 16'h0001, 16'h0001);
      send_encode(16'h0001, 16'h0000, 16'h0000);
      send_encode(16'h0000, 16'h0000, 16'h0000);
      send_encode(16'hc000, 16'h4000, 16'hffff);
      send_encode(16'h0000, 16'hc000, 16'h0000);
      send_decode(16'h0000);
      send_decode(16'hffff);
      send_decode(16'h1f80);
      send_decode(16'h007f);
      send_decode(16'he03f);
      send_decode(16'h1fc0);
      send_decode(16'h2000);
      send_decode(16'h1001);
      write_threshold(32'd0);
      send_encode(16'h0000, 16'h0000, 16'h0000);
      send_encode(16'h0000, 16'h8000, 16'h0001);
      write_threshold(32'hffffffff);
      send_encode(16'h8000, 16'h8000, 16'h8000);
      send_encode(16'h1234, 16'hedcb, 16'h0100);

      // Random phases over several thresholds.
      write_threshold(32'd3);
      random_phase(500);
      write_threshold(32'd0);
      random_phase(450);
      write_threshold(32'h1000_0000);
      random_phase(450);
      write_threshold(32'($urandom));
      random_phase(450);

      idle_request();
      stimulus_done = 1'b1;
   end

   initial begin : verdict
      wait (stimulus_done);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY * 2) @(posedge clock);
      $display("Covered %0d encodes (%0d below threshold) and %0d decodes.",
               encodes_seen, tiny_seen, decodes_seen);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin : watchdog
      #4ms;
      $display("FAILURE");
      $finish;
   end
endmodule

`default_nettype wire
